FILE: sv/mpnm_pkg.sv
// ----------------------------------------------------------------------------
// Pattern matcher package
// Shared types, operation codes and helpers for the case-insensitive matcher.
// ----------------------------------------------------------------------------
package mpnm_pkg;

    localparam int SLOTS   = 16;
    localparam int MAXLEN  = 32;
    localparam int SLOT_W  = 4;
    localparam int POS_W   = 5;
    localparam int LEN_W   = 6;
    localparam int QDEPTH  = 2;

    localparam logic [1:0] OP_PBYTE   = 2'd0;
    localparam logic [1:0] OP_HEADER  = 2'd1;
    localparam logic [1:0] OP_CONTENT = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] pattern_slot;
        logic [4:0] byte_position;
        logic [7:0] data_byte;
        logic [5:0] pattern_length;
        logic [7:0] pattern_severity;
        logic [7:0] pattern_kind;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [4:0] match_count;
        logic [7:0] peak_severity;
        logic [7:0] max_kind;
        logic [2:0] threat_level;
    } out_item_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic       is_pbyte;
        logic       is_header;
        logic       is_content;
        logic       last;
        logic [3:0] slot;
        logic [4:0] pos;
        logic [7:0] data;
        logic [5:0] len;
        logic [7:0] sev;
        logic [7:0] kind;
    } cmd_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: sv/mpnm_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface mpnm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/mpnm_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accept input beats, classify them and push commands into a short queue.
// ----------------------------------------------------------------------------
module mpnm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    mpnm_stream_if.sink          in_ch,
    output mpnm_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  logic                 cmd_pop
);

    mpnm_pkg::cmd_t q_reg [mpnm_pkg::QDEPTH];
    logic           rd_reg, rd_next;
    logic           wr_reg, wr_next;
    logic [1:0]     cnt_reg, cnt_next;
    mpnm_pkg::cmd_t c;
    logic           push;

    // Classify the incoming beat; unused operations are dropped
    always_comb
    begin
        c.is_pbyte   = in_ch.payload.operation == mpnm_pkg::OP_PBYTE;
        c.is_header  = in_ch.payload.operation == mpnm_pkg::OP_HEADER;
        c.is_content = in_ch.payload.operation == mpnm_pkg::OP_CONTENT;
        c.last       = in_ch.payload.last_byte;
        c.slot       = in_ch.payload.pattern_slot;
        c.pos        = in_ch.payload.byte_position;
        c.data       = in_ch.payload.data_byte;
        c.len        = in_ch.payload.pattern_length;
        c.sev        = in_ch.payload.pattern_severity;
        c.kind       = in_ch.payload.pattern_kind;
    end

    assign in_ch.ready = cnt_reg != 2'(mpnm_pkg::QDEPTH);
    assign push        = in_ch.valid && in_ch.ready
                         && (c.is_pbyte || c.is_header || c.is_content);
    assign cmd_valid   = cnt_reg != 2'd0;
    assign cmd         = q_reg[rd_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = cmd_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

endmodule

FILE: sv/mpnm_back.sv
// ----------------------------------------------------------------------------
// Back end
// Execute commands: pattern loads, window update, per-slot compare sweep and
// the result reduction on the final content byte.
// ----------------------------------------------------------------------------
module mpnm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mpnm_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    mpnm_stream_if.source        out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_RED  = 2'd3;

    logic [mpnm_pkg::MAXLEN*8-1:0] store_mem [mpnm_pkg::SLOTS];
    logic [mpnm_pkg::MAXLEN*8-1:0] row_reg;
    logic [5:0]  len_reg  [mpnm_pkg::SLOTS];
    logic [7:0]  sev_reg  [mpnm_pkg::SLOTS];
    logic [7:0]  kind_reg [mpnm_pkg::SLOTS];
    logic [7:0]  win_reg  [mpnm_pkg::MAXLEN];
    logic [5:0]  seen_reg;
    logic [15:0] found_reg;
    logic [1:0]  st_reg;
    logic [3:0]  s_reg;
    logic        last_reg;
    logic [4:0]  cnt_reg;
    logic [7:0]  msev_reg, mkind_reg;
    logic        hit;
    logic        busy_out;
    logic        emit;
    logic        last_done_reg;
    mpnm_pkg::out_item_t res_reg;
    logic        res_v_reg;

    assign out_ch.valid   = res_v_reg;
    assign out_ch.payload = res_reg;
    assign busy_out       = res_v_reg && !out_ch.ready;
    assign cmd_pop        = cmd_valid && st_reg == ST_IDLE;
    assign emit           = st_reg == ST_RED && s_reg == 4'(mpnm_pkg::SLOTS - 1)
                            && !busy_out;

    // Compare the newest window bytes against the fetched row
    always_comb
    begin
        logic [5:0] l;
        l   = len_reg[s_reg];
        hit = l != 6'd0 && l <= 6'(mpnm_pkg::MAXLEN) && l <= seen_reg;
        for (int i = 0; i < mpnm_pkg::MAXLEN; i++)
        begin
            if (6'(i) < l && mpnm_pkg::fold(win_reg[i])
                != mpnm_pkg::fold(row_reg[(l - 6'd1 - 6'(i))*8 +: 8]))
            begin
                hit = 1'b0;
            end
        end
    end

    // Pattern row memory
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.is_pbyte)
        begin
            store_mem[cmd.slot][cmd.pos*8 +: 8] <= cmd.data;
        end
        if (st_reg == ST_RD)
        begin
            row_reg <= store_mem[s_reg];
        end
        if (cmd_pop && cmd.is_header)
        begin
            sev_reg[cmd.slot]  <= cmd.sev;
            kind_reg[cmd.slot] <= cmd.kind;
        end
    end

    // Sequencer: one slot per compare, then reduction over the found marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            s_reg     <= 4'd0;
            seen_reg  <= 6'd0;
            found_reg <= 16'd0;
            res_v_reg <= 1'b0;
            last_reg  <= 1'b0;
            for (int i = 0; i < mpnm_pkg::SLOTS; i++)
            begin
                len_reg[i] <= 6'd0;
            end
            for (int i = 0; i < mpnm_pkg::MAXLEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else
        begin
            // Raise on a new result, drop once the beat is taken
            if (emit)
            begin
                res_v_reg <= 1'b1;
            end
            else if (res_v_reg && out_ch.ready)
            begin
                res_v_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    if (cmd_pop && cmd.is_header)
                    begin
                        len_reg[cmd.slot] <= cmd.len;
                    end
                    if (cmd_pop && cmd.is_content)
                    begin
                        win_reg[0] <= cmd.data;
                        for (int i = 1; i < mpnm_pkg::MAXLEN; i++)
                        begin
                            win_reg[i] <= win_reg[i-1];
                        end
                        if (seen_reg != 6'(mpnm_pkg::MAXLEN))
                        begin
                            seen_reg <= seen_reg + 6'd1;
                        end
                        last_reg <= cmd.last;
                        s_reg    <= 4'd0;
                        st_reg   <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    st_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (hit)
                    begin
                        found_reg[s_reg] <= 1'b1;
                    end
                    if (s_reg == 4'(mpnm_pkg::SLOTS - 1))
                    begin
                        s_reg  <= 4'd0;
                        st_reg <= last_reg ? ST_RED : ST_IDLE;
                    end
                    else
                    begin
                        s_reg  <= s_reg + 4'd1;
                        st_reg <= ST_RD;
                    end
                end
                ST_RED:
                begin
                    if (emit)
                    begin
                        found_reg <= 16'd0;
                        seen_reg  <= 6'd0;
                        st_reg    <= ST_IDLE;
                        for (int i = 0; i < mpnm_pkg::MAXLEN; i++)
                        begin
                            win_reg[i] <= 8'd0;
                        end
                    end
                    else if (s_reg != 4'(mpnm_pkg::SLOTS - 1))
                    begin
                        s_reg <= s_reg + 4'd1;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Reduce count and maximum severity, one slot per cycle
    always_ff @(posedge clk)
    begin
        logic [4:0] c;
        logic [7:0] ms, mk;
        c  = cnt_reg;
        ms = msev_reg;
        mk = mkind_reg;
        if (st_reg == ST_CMP && s_reg == 4'(mpnm_pkg::SLOTS - 1))
        begin
            cnt_reg   <= 5'd0;
            msev_reg  <= 8'd0;
            mkind_reg <= 8'd0;
        end
        else if (st_reg == ST_RED)
        begin
            if (!(s_reg == 4'(mpnm_pkg::SLOTS - 1) && last_done_reg))
            begin
                if (found_reg[s_reg])
                begin
                    c = c + 5'd1;
                    if (sev_reg[s_reg] > ms)
                    begin
                        ms = sev_reg[s_reg];
                        mk = kind_reg[s_reg];
                    end
                end
                cnt_reg   <= c;
                msev_reg  <= ms;
                mkind_reg <= mk;
            end
            if (emit)
            begin
                res_reg.match_count   <= c;
                res_reg.peak_severity <= ms;
                res_reg.max_kind      <= mk;
                res_reg.threat_level  <= (c != 5'd0 && ms >= 8'd1 && ms <= 8'd4)
                                         ? ms[2:0] : 3'd0;
            end
        end
    end

    // Last slot is folded only once, while waiting for the output to drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_done_reg <= 1'b0;
        end
        else
        begin
            last_done_reg <= st_reg == ST_RED && s_reg == 4'(mpnm_pkg::SLOTS - 1)
                             && busy_out;
        end
    end

endmodule

FILE: sv/multi_pattern_nocase_matcher_core.sv
// ----------------------------------------------------------------------------
// Case-insensitive multi-pattern matcher
// The final content beat passes the command queue, then a row fetch and compare
//   for each slot and a reduction step per slot; then the result beat is valid.
// Loads run in the idle state; a content byte holds the back end while it is
//   issued and each slot is fetched and compared, set by the one row port.
// A stalled result holds only the next reduction. Reset clears slots, window, marks.
// ----------------------------------------------------------------------------
module multi_pattern_nocase_matcher_core (
    input  logic          clk,
    input  logic          rst_n,
    mpnm_stream_if.sink   in_ch,
    mpnm_stream_if.source out_ch
);

    mpnm_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    mpnm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    mpnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

FILE: sv/mpnm_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Observes the matcher's result port and flags out-of-contract behaviour.
// ----------------------------------------------------------------------------
module mpnm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input mpnm_pkg::out_item_t out_payload
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    // Count stays within the slot count
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.match_count <= 5'(mpnm_pkg::SLOTS))
        else $error("match count out of range");

    // Nothing found means no severity and no threat
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.match_count == 5'd0
        |-> out_payload.peak_severity == 8'd0 && out_payload.threat_level == 3'd0)
        else $error("severity without a match");

    // Threat level follows severity
    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.threat_level != 3'd0
        |-> out_payload.peak_severity == {5'd0, out_payload.threat_level})
        else $error("threat level mismatch");

endmodule

bind multi_pattern_nocase_matcher_core mpnm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
